[rtl/core/sfc_pkg.sv]
// Shared types, constants and header decode functions for the serial frame checker.
package sfc_pkg;

  localparam int BYTE_W      = 8;
  localparam int POS_W       = 9;
  localparam int SUM_W       = 16;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 16;
  localparam int OUT_TDATA_W = 48;

  localparam logic [POS_W-1:0] POS_MAX = 9'd511;

  localparam logic [7:0]  HDR_SYNC = 8'h55;
  localparam logic [7:0]  HDR_V1   = 8'hAA;
  localparam logic [7:0]  HDR_V2   = 8'hBB;
  localparam logic [15:0] FUNC_ANY = 16'hFFFF;

  localparam logic [1:0] VER_NONE = 2'd0;
  localparam logic [1:0] VER_1    = 2'd1;
  localparam logic [1:0] VER_2    = 2'd2;

  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_LEN   = 3'd1;
  localparam logic [2:0] ST_HDR   = 3'd2;
  localparam logic [2:0] ST_ADDR  = 3'd3;
  localparam logic [2:0] ST_FUNC  = 3'd4;
  localparam logic [2:0] ST_CSUM  = 3'd5;

  localparam logic [CFG_INDEX_W-1:0] CFG_EXP_ADDR = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_EXP_FUNC = 1'b1;

  typedef struct packed {
    logic        is_status;
    logic [7:0]  payload_byte;
    logic [2:0]  status_code;
    logic [1:0]  version;
    logic [7:0]  source_address;
    logic [15:0] function_code;
    logic [7:0]  payload_length;
    logic        last;
  } sfc_result_t;

  typedef struct packed {
    logic        valid0;
    logic        valid1;
    sfc_result_t res0;
    sfc_result_t res1;
  } sfc_push_t;

  function automatic logic [1:0] frame_version(input logic [7:0] hi, input logic [7:0] lo);
    logic [1:0] v;
    v = VER_NONE;
    if (hi == HDR_SYNC) begin
      if (lo == HDR_V1) v = VER_1;
      else if (lo == HDR_V2) v = VER_2;
    end
    return v;
  endfunction

  function automatic logic [7:0] payload_len(input logic [1:0] ver, input logic [7:0] len);
    logic [7:0] p;
    p = 8'd0;
    if (ver == VER_1) p = (len >= 8'd2) ? len - 8'd2 : 8'd0;
    else if (ver == VER_2) p = len;
    return p;
  endfunction

endpackage

[rtl/core/serial_frame_checker.sv]
// Top level of the serial reply-frame checker.
//
// Input stream: one received frame byte per transfer in in_tdata, in_tlast on
// the last byte of a frame. Output stream: one result per transfer; out_tuser
// is 0 for a payload byte and 1 for the end-of-frame status, which also has
// out_tlast set. A payload byte and a status caused by the same input byte
// come out in that order. Configuration writes on the cfg_ channel set the
// expected address (index 0) and function code (index 1); cfg_ready is always
// high, and writes belong in idle periods.
// Each result is registered in the result queue when its input byte is taken.
// Throughput: one input byte per cycle; the input side takes a byte whenever
// the result queue has room for two entries, so an output stall backs up into
// in_tready after QUEUE_DEPTH - 1 results are pending. A byte ending a frame
// on a payload byte yields two results, drained one per cycle unless stalled.
// Reset (rst_n low, synchronous) clears the frame state, configuration and
// the result queue; the next byte taken starts a new frame.
module serial_frame_checker
  import sfc_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [7:0]             in_tdata,    // [7:0] frame_byte
  input  logic                   in_tlast,    // frame_end
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [7:0] payload_byte, [10:8] status_code, [12:11] version,
  // [20:13] source_address, [36:21] function_code, [44:37] payload_length
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tuser,   // is_status
  output logic                   out_tlast,   // last
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  sfc_push_t   push;
  sfc_result_t res;
  logic        room;
  logic        accept;

  assign in_tready = room;
  assign accept    = in_tvalid && room;
  assign cfg_ready = 1'b1;

  sfc_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .frame_byte (in_tdata),
    .frame_end  (in_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .push       (push)
  );

  sfc_result_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .pop       (out_tvalid && out_tready),
    .room      (room),
    .out_valid (out_tvalid),
    .out_res   (res)
  );

  assign out_tdata = {3'b000, res.payload_length, res.function_code, res.source_address,
                      res.version, res.status_code, res.payload_byte};
  assign out_tuser = res.is_status;
  assign out_tlast = res.last;

endmodule

[rtl/core/sfc_parser.sv]
// Per-byte frame decode: field capture, checksum, payload and status results.
module sfc_parser
  import sfc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   accept,
  input  logic [BYTE_W-1:0]      frame_byte,
  input  logic                   frame_end,
  input  logic                   cfg_valid,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output sfc_push_t              push
);

  logic [7:0]       exp_addr_r;
  logic [15:0]      exp_func_r;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [7:0]       hdr_hi_r, hdr_hi_nxt;
  logic [7:0]       hdr_lo_r, hdr_lo_nxt;
  logic [7:0]       addr_r, addr_nxt;
  logic [7:0]       len_r, len_nxt;
  logic [15:0]      func_r, func_nxt;
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [SUM_W-1:0] rx_sum_r, rx_sum_nxt;

  logic [1:0]       ver;
  logic [7:0]       plen;
  logic [9:0]       pos_ext;
  logic [9:0]       body_end;
  logic             payload;
  logic [2:0]       code;
  sfc_result_t      pay_res;
  sfc_result_t      st_res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_addr_r <= '0;
      exp_func_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_EXP_ADDR: exp_addr_r <= cfg_data[7:0];
        CFG_EXP_FUNC: exp_func_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    hdr_hi_nxt = hdr_hi_r;
    hdr_lo_nxt = hdr_lo_r;
    addr_nxt   = addr_r;
    len_nxt    = len_r;
    func_nxt   = func_r;
    sum_nxt    = sum_r;
    rx_sum_nxt = rx_sum_r;
    payload    = 1'b0;

    if (pos_r == 9'd0) begin
      hdr_hi_nxt = frame_byte;
      hdr_lo_nxt = '0;
      addr_nxt   = '0;
      len_nxt    = '0;
      func_nxt   = '0;
      sum_nxt    = '0;
      rx_sum_nxt = '0;
    end else if (pos_r == 9'd1) begin
      hdr_lo_nxt = frame_byte;
    end else begin
      case (pos_r)
        9'd2: addr_nxt = frame_byte;
        9'd3: len_nxt = frame_byte;
        9'd4: func_nxt = {frame_byte, func_r[7:0]};
        9'd5: func_nxt = {func_r[15:8], frame_byte};
        default: ;
      endcase
    end

    ver      = frame_version(hdr_hi_nxt, hdr_lo_nxt);
    plen     = payload_len(ver, len_nxt);
    pos_ext  = {1'b0, pos_r};
    body_end = 10'd6 + {2'b00, plen};

    if (pos_r >= 9'd2) begin
      if (pos_ext < body_end) sum_nxt = sum_r + {8'd0, frame_byte};
      payload = (ver != VER_NONE) && (pos_r >= 9'd6) && (pos_ext < body_end);
      if (pos_ext == body_end) rx_sum_nxt = {rx_sum_r[15:8], frame_byte};
      else if (pos_ext == body_end + 10'd1) rx_sum_nxt = {frame_byte, rx_sum_r[7:0]};
    end

    if (pos_r == 9'd0) code = ST_LEN;
    else if (ver == VER_NONE) code = ST_HDR;
    else if ((ver == VER_1 && len_nxt < 8'd2) || (pos_ext + 10'd1 < body_end + 10'd2))
      code = ST_LEN;
    else if (addr_nxt != exp_addr_r) code = ST_ADDR;
    else if (func_nxt != exp_func_r && func_nxt != FUNC_ANY) code = ST_FUNC;
    else if (sum_nxt != rx_sum_nxt) code = ST_CSUM;
    else code = ST_OK;

    if (frame_end) pos_nxt = '0;
    else if (pos_r == POS_MAX) pos_nxt = pos_r;
    else pos_nxt = pos_r + 1'b1;

    pay_res.is_status      = 1'b0;
    pay_res.payload_byte   = frame_byte;
    pay_res.status_code    = ST_OK;
    pay_res.version        = ver;
    pay_res.source_address = addr_nxt;
    pay_res.function_code  = func_nxt;
    pay_res.payload_length = plen;
    pay_res.last           = 1'b0;

    st_res                 = pay_res;
    st_res.is_status       = 1'b1;
    st_res.payload_byte    = '0;
    st_res.status_code     = code;
    st_res.last            = 1'b1;

    push.valid0 = accept && (payload || frame_end);
    push.valid1 = accept && payload && frame_end;
    push.res0   = payload ? pay_res : st_res;
    push.res1   = st_res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      hdr_hi_r <= '0;
      hdr_lo_r <= '0;
      addr_r   <= '0;
      len_r    <= '0;
      func_r   <= '0;
      sum_r    <= '0;
      rx_sum_r <= '0;
    end else if (accept) begin
      pos_r    <= pos_nxt;
      hdr_hi_r <= hdr_hi_nxt;
      hdr_lo_r <= hdr_lo_nxt;
      addr_r   <= addr_nxt;
      len_r    <= len_nxt;
      func_r   <= func_nxt;
      sum_r    <= sum_nxt;
      rx_sum_r <= rx_sum_nxt;
    end
  end

endmodule

[rtl/core/sfc_result_queue.sv]
// Small result queue taking up to two results per cycle and giving one per transfer.
module sfc_result_queue
  import sfc_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  sfc_push_t   push,
  input  logic        pop,
  output logic        room,
  output logic        out_valid,
  output sfc_result_t out_res
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  sfc_result_t      mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, wr_ptr_p1;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign wr_ptr_p1 = ptr_inc(wr_ptr_r);
  assign room      = count_r <= CNT_W'(DEPTH - 2);
  assign out_valid = count_r != '0;
  assign out_res   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    if (push.valid1) wr_ptr_nxt = ptr_inc(wr_ptr_p1);
    else if (push.valid0) wr_ptr_nxt = wr_ptr_p1;
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r + CNT_W'(push.valid0) + CNT_W'(push.valid1) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.valid0) mem_r[wr_ptr_r] <= push.res0;
    if (push.valid1) mem_r[wr_ptr_p1] <= push.res1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

[rtl/core/sfc_checker.sv]
// Port-level checks for the serial frame checker, bound to the top level.
module sfc_checker
  import sfc_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic                   out_tuser,
  input logic                   out_tlast
);

  a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("out_tvalid dropped while stalled");

  a_data_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))
    else $error("result changed while stalled");

  a_last_is_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tlast == out_tuser)
    else $error("tlast and status flag disagree");

  a_payload_code_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[10:8] == ST_OK && out_tdata[12:11] != VER_NONE)
    else $error("payload result with status code or unknown header");

  a_status_no_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[7:0] == 8'd0)
    else $error("status result carries a payload byte");

endmodule

bind serial_frame_checker sfc_checker u_sfc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
